// File: rtl/assert_macros.svh
// Assertion macros for the RTL files; only the top level includes them.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, cond, msg)
`endif
`endif

// File: rtl/lxst_pkg.sv
// Types, token codes and keyword tables for the lexer with symbol table.
// No dependencies.
package lxst_pkg;

   // Token kinds
   localparam logic [2:0] KIND_KEYWORD = 3'd0;
   localparam logic [2:0] KIND_NUMBER  = 3'd1;
   localparam logic [2:0] KIND_IDENT   = 3'd2;
   localparam logic [2:0] KIND_DELIM   = 3'd3;
   localparam logic [2:0] KIND_SPACE   = 3'd4;

   localparam int NUM_KEYWORDS = 6;
   localparam int KW_MAX_LEN   = 6;

   // Controller states
   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_KW_RD     = 12'b0000_0000_0010,
      ST_KW_CMP    = 12'b0000_0000_0100,
      ST_CLASSIFY  = 12'b0000_0000_1000,
      ST_LEN_RD    = 12'b0000_0001_0000,
      ST_LEN_CMP   = 12'b0000_0010_0000,
      ST_CH_RD     = 12'b0000_0100_0000,
      ST_CH_CMP    = 12'b0000_1000_0000,
      ST_CP_RD     = 12'b0001_0000_0000,
      ST_CP_WR     = 12'b0010_0000_0000,
      ST_TOK_OUT   = 12'b0100_0000_0000,
      ST_DELIM_OUT = 12'b1000_0000_0000
   } state_type;

   // Which lexeme token the datapath builds
   typedef enum logic [2:0] {
      RES_KW,
      RES_NUM,
      RES_FOUND,
      RES_NEW,
      RES_FULL
   } res_sel_type;

   typedef struct packed {
      logic        accept;
      logic        kw_step;
      logic        set_res;
      res_sel_type res_sel;
      logic        next_entry;
      logic        clr_j;
      logic        step_j;
      logic        cp_write;
      logic        store_new;
      logic        load_tok;
      logic        load_delim;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_delim;
      logic len_zero;
      logic kw_more;
      logic kw_hit;
      logic is_num;
      logic count_zero;
      logic table_room;
      logic len_eq;
      logic e_more;
      logic ch_eq;
      logic j_more;
      logic out_free;
   } dp_status_type;

   function automatic logic char_is_delim(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h28 ||
             c == 8'h29 || c == 8'h7B || c == 8'h7D || c == 8'h3B ||
             c == 8'h3D || c == 8'h3C || c == 8'h3E || c == 8'h2A;
   endfunction

   function automatic logic char_is_space(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A;
   endfunction

   // Keyword lengths: int main if else char return
   function automatic logic [2:0] kw_len(input logic [2:0] i);
      logic [2:0] r;
      case (i)
         3'd0: r = 3'd3;
         3'd1: r = 3'd4;
         3'd2: r = 3'd2;
         3'd3: r = 3'd4;
         3'd4: r = 3'd4;
         3'd5: r = 3'd6;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // Keyword character j of keyword i
   function automatic logic [7:0] kw_char(input logic [2:0] i, input logic [2:0] j);
      logic [47:0] s;
      case (i)
         3'd0: s = {"int",    24'h0};
         3'd1: s = {"main",   16'h0};
         3'd2: s = {"if",     32'h0};
         3'd3: s = {"else",   16'h0};
         3'd4: s = {"char",   16'h0};
         3'd5: s = "return";
         default: s = 48'h0;
      endcase
      case (j)
         3'd0: return s[47:40];
         3'd1: return s[39:32];
         3'd2: return s[31:24];
         3'd3: return s[23:16];
         3'd4: return s[15:8];
         3'd5: return s[7:0];
         default: return 8'h0;
      endcase
   endfunction

endpackage

// File: rtl/lexer_with_symbol_table.sv
// Top level of the lexer with symbol table: controller plus datapath.
// Depends on lxst_pkg, lxst_ctrl, lxst_dp, lxst_ram and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | req_char_code
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_token_kind, rsp_token_value,
//           |           |                    | rsp_table_full, rsp_last
//
// An ordinary byte is accepted in ST_IDLE, which stays ready for the next one.
// A delimiter runs the keyword check over at most six lexeme characters, then
// a length check of each stored entry with a character compare for each of equal
// length, a copy to insert a new identifier, and one output state per token.
// Reset is synchronous and needs no clearing pass. A stalled result holds in
// the output register while the block keeps working up to the next load.
`include "assert_macros.svh"
module lexer_with_symbol_table import lxst_pkg::*; #(
   parameter int MAX_LEXEME  = 32,
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic [15:0] rsp_token_value,
   output logic        rsp_table_full,
   output logic        rsp_last
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   lxst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lxst_dp #(
      .MAX_LEXEME  (MAX_LEXEME),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_char_code   (req_char_code),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_value (rsp_token_value),
      .rsp_table_full  (rsp_table_full),
      .rsp_last        (rsp_last)
   );

   // A delimiter transaction always starts a multi-cycle sequence
   `ASSERT_CLK(a_delim_busy, clock, reset, req_valid && !req_stall && char_is_delim(req_char_code) |=> req_stall, "delimiter did not start token sequence")
   // The closing token of a byte is always the delimiter itself
   `ASSERT_CLK(a_last_kind, clock, reset, rsp_valid && rsp_last |-> (rsp_token_kind == KIND_DELIM || rsp_token_kind == KIND_SPACE), "last token is not a delimiter")
   // Full-table flag only on an identifier token with value zero
   `ASSERT_NEVER(a_full_ident, clock, reset, rsp_valid && rsp_table_full && (rsp_token_kind != KIND_IDENT || rsp_token_value != 16'd0 || rsp_last), "bad table full token")

endmodule

// File: rtl/lxst_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lxst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lxst_dp.sv
// Datapath: lexeme buffer, symbol table memories, counters, comparators and
// the result register. Depends on lxst_pkg and lxst_ram.
module lxst_dp import lxst_pkg::*; #(
   parameter int MAX_LEXEME  = 32,
   parameter int TABLE_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    req_char_code,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output logic [2:0]    rsp_token_kind,
   output logic [15:0]   rsp_token_value,
   output logic          rsp_table_full,
   output logic          rsp_last
);

   localparam int LW  = $clog2(MAX_LEXEME + 1);
   localparam int LW1 = LW + 1;
   localparam int LAW = $clog2(MAX_LEXEME);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int CW1 = CW + 1;
   localparam int EAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SD  = TABLE_DEPTH * MAX_LEXEME;
   localparam int SAW = $clog2(SD);
   localparam int BW  = $clog2(SD + 1);

   logic [LW-1:0]  len_ff, len_in;
   logic [LW-1:0]  j_ff, j_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  e_ff, e_in;
   logic [BW-1:0]  base_ff, base_in;
   logic [15:0]    num_ff, num_in;
   logic [NUM_KEYWORDS-1:0] match_ff, match_in;
   logic [7:0]     first_ff, first_in;
   logic [7:0]     delim_ff, delim_in;
   logic [2:0]     res_kind_ff, res_kind_in;
   logic [15:0]    res_value_ff, res_value_in;
   logic           res_full_ff, res_full_in;
   logic           out_valid_ff, out_valid_in;
   logic [2:0]     out_kind_ff, out_kind_in;
   logic [15:0]    out_value_ff, out_value_in;
   logic           out_full_ff, out_full_in;
   logic           out_last_ff, out_last_in;

   logic           in_delim;
   logic           lex_wr_en;
   logic [7:0]     lex_rdata, sym_rdata;
   logic [LW-1:0]  lens_rdata;
   logic [BW-1:0]  sym_addr;
   logic [2:0]     kw_idx;

   assign in_delim  = char_is_delim(req_char_code);
   assign lex_wr_en = cmd.accept && !in_delim && (len_ff < LW'(MAX_LEXEME));
   assign sym_addr  = base_ff + BW'(j_ff);

   lxst_ram #(.WIDTH(8), .DEPTH(MAX_LEXEME)) u_lex_ram (
      .clock   (clock),
      .wr_en   (lex_wr_en),
      .wr_addr (len_ff[LAW-1:0]),
      .wr_data (req_char_code),
      .rd_addr (j_ff[LAW-1:0]),
      .rd_data (lex_rdata)
   );

   lxst_ram #(.WIDTH(8), .DEPTH(SD)) u_sym_ram (
      .clock   (clock),
      .wr_en   (cmd.cp_write),
      .wr_addr (sym_addr[SAW-1:0]),
      .wr_data (lex_rdata),
      .rd_addr (sym_addr[SAW-1:0]),
      .rd_data (sym_rdata)
   );

   lxst_ram #(.WIDTH(LW), .DEPTH(TABLE_DEPTH)) u_len_ram (
      .clock   (clock),
      .wr_en   (cmd.store_new),
      .wr_addr (count_ff[EAW-1:0]),
      .wr_data (len_ff),
      .rd_addr (e_ff[EAW-1:0]),
      .rd_data (lens_rdata)
   );

   // Keyword index from the match vector
   always_comb begin
      kw_idx = 3'd0;
      for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
         if (match_ff[i]) kw_idx = 3'(i);
      end
   end

   // Status to the controller
   always_comb begin
      status.is_delim   = in_delim;
      status.len_zero   = (len_ff == '0);
      status.j_more     = (LW1'(j_ff) + LW1'(1)) < LW1'(len_ff);
      status.kw_more    = status.j_more && ((LW1'(j_ff) + LW1'(1)) < LW1'(KW_MAX_LEN));
      status.kw_hit     = |match_ff;
      status.is_num     = (first_ff >= 8'h30) && (first_ff <= 8'h39);
      status.count_zero = (count_ff == '0);
      status.table_room = count_ff < CW'(TABLE_DEPTH);
      status.len_eq     = (lens_rdata == len_ff);
      status.e_more     = (CW1'(e_ff) + CW1'(1)) < CW1'(count_ff);
      status.ch_eq      = (lex_rdata == sym_rdata);
      status.out_free   = !out_valid_ff || !rsp_stall;
   end

   // Next-state of counters and work registers
   always_comb begin
      len_in   = len_ff;
      j_in     = j_ff;
      count_in = count_ff;
      e_in     = e_ff;
      base_in  = base_ff;
      num_in   = num_ff;
      match_in = match_ff;
      first_in = first_ff;
      delim_in = delim_ff;

      if (lex_wr_en) len_in = len_ff + LW'(1);
      if (cmd.load_delim) len_in = '0;

      if (cmd.accept && in_delim) begin
         j_in     = '0;
         e_in     = '0;
         base_in  = '0;
         delim_in = req_char_code;
         for (int i = 0; i < NUM_KEYWORDS; i++) begin
            match_in[i] = (LW'(kw_len(3'(i))) == len_ff);
         end
      end

      if (cmd.kw_step) begin
         for (int i = 0; i < NUM_KEYWORDS; i++) begin
            match_in[i] = match_ff[i] && (kw_char(3'(i), j_ff[2:0]) == lex_rdata);
         end
         if (j_ff == '0) first_in = lex_rdata;
      end

      if (cmd.clr_j) j_in = '0;
      if (cmd.kw_step || cmd.step_j || cmd.cp_write) j_in = j_ff + LW'(1);

      if (cmd.next_entry) begin
         e_in    = e_ff + CW'(1);
         base_in = base_ff + BW'(MAX_LEXEME);
      end

      if (cmd.store_new) count_in = count_ff + CW'(1);
      if (cmd.set_res && cmd.res_sel == RES_NUM) num_in = num_ff + 16'd1;
   end

   // Lexeme token under construction
   always_comb begin
      res_kind_in  = res_kind_ff;
      res_value_in = res_value_ff;
      res_full_in  = res_full_ff;
      if (cmd.set_res) begin
         res_full_in = 1'b0;
         case (cmd.res_sel)
            RES_KW: begin
               res_kind_in  = KIND_KEYWORD;
               res_value_in = 16'(kw_idx);
            end
            RES_NUM: begin
               res_kind_in  = KIND_NUMBER;
               res_value_in = num_ff + 16'd1;
            end
            RES_FOUND: begin
               res_kind_in  = KIND_IDENT;
               res_value_in = 16'(e_ff) + 16'd1;
            end
            RES_NEW: begin
               res_kind_in  = KIND_IDENT;
               res_value_in = 16'(count_ff) + 16'd1;
            end
            RES_FULL: begin
               res_kind_in  = KIND_IDENT;
               res_value_in = 16'd0;
               res_full_in  = 1'b1;
            end
            default: begin
               res_kind_in  = res_kind_ff;
            end
         endcase
      end
   end

   // Output register
   always_comb begin
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_full_in  = out_full_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.load_tok) begin
         out_valid_in = 1'b1;
         out_kind_in  = res_kind_ff;
         out_value_in = res_value_ff;
         out_full_in  = res_full_ff;
         out_last_in  = 1'b0;
      end else if (cmd.load_delim) begin
         out_valid_in = 1'b1;
         out_kind_in  = char_is_space(delim_ff) ? KIND_SPACE : KIND_DELIM;
         out_value_in = 16'(delim_ff);
         out_full_in  = 1'b0;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         count_ff     <= '0;
         num_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         count_ff     <= count_in;
         num_ff       <= num_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      e_ff         <= e_in;
      base_ff      <= base_in;
      match_ff     <= match_in;
      first_ff     <= first_in;
      delim_ff     <= delim_in;
      res_kind_ff  <= res_kind_in;
      res_value_ff <= res_value_in;
      res_full_ff  <= res_full_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_full_ff  <= out_full_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_token_kind  = out_kind_ff;
   assign rsp_token_value = out_value_ff;
   assign rsp_table_full  = out_full_ff;
   assign rsp_last        = out_last_ff;

endmodule

// File: rtl/lxst_ctrl.sv
// Controller: sequences keyword check, table search, insertion and token output.
// Depends on lxst_pkg.
module lxst_ctrl import lxst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      cmd.res_sel = RES_KW;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.is_delim) begin
                  state_in = status.len_zero ? ST_DELIM_OUT : ST_KW_RD;
               end
            end
         end
         ST_KW_RD: begin
            state_in = ST_KW_CMP;
         end
         // Compare one lexeme character against all keywords
         ST_KW_CMP: begin
            cmd.kw_step = 1'b1;
            state_in = status.kw_more ? ST_KW_RD : ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            if (status.kw_hit) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_KW;
               state_in = ST_TOK_OUT;
            end else if (status.is_num) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_NUM;
               state_in = ST_TOK_OUT;
            end else if (!status.count_zero) begin
               state_in = ST_LEN_RD;
            end else if (status.table_room) begin
               cmd.clr_j = 1'b1;
               state_in = ST_CP_RD;
            end else begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_FULL;
               state_in = ST_TOK_OUT;
            end
         end
         ST_LEN_RD: begin
            state_in = ST_LEN_CMP;
         end
         // Length check: compare characters, next entry, insert or full-table token
         ST_LEN_CMP: begin
            if (status.len_eq) begin
               cmd.clr_j = 1'b1;
               state_in = ST_CH_RD;
            end else begin
               cmd.next_entry = 1'b1;
               if (status.e_more) begin
                  state_in = ST_LEN_RD;
               end else if (status.table_room) begin
                  cmd.clr_j = 1'b1;
                  state_in = ST_CP_RD;
               end else begin
                  cmd.set_res = 1'b1;
                  cmd.res_sel = RES_FULL;
                  state_in = ST_TOK_OUT;
               end
            end
         end
         ST_CH_RD: begin
            state_in = ST_CH_CMP;
         end
         ST_CH_CMP: begin
            if (!status.ch_eq) begin
               cmd.next_entry = 1'b1;
               if (status.e_more) begin
                  state_in = ST_LEN_RD;
               end else if (status.table_room) begin
                  cmd.clr_j = 1'b1;
                  state_in = ST_CP_RD;
               end else begin
                  cmd.set_res = 1'b1;
                  cmd.res_sel = RES_FULL;
                  state_in = ST_TOK_OUT;
               end
            end else if (status.j_more) begin
               cmd.step_j = 1'b1;
               state_in = ST_CH_RD;
            end else begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_FOUND;
               state_in = ST_TOK_OUT;
            end
         end
         ST_CP_RD: begin
            state_in = ST_CP_WR;
         end
         // Copy one character into the new entry
         ST_CP_WR: begin
            cmd.cp_write = 1'b1;
            if (status.j_more) begin
               state_in = ST_CP_RD;
            end else begin
               cmd.store_new = 1'b1;
               cmd.set_res   = 1'b1;
               cmd.res_sel   = RES_NEW;
               state_in = ST_TOK_OUT;
            end
         end
         ST_TOK_OUT: begin
            if (status.out_free) begin
               cmd.load_tok = 1'b1;
               state_in = ST_DELIM_OUT;
            end
         end
         ST_DELIM_OUT: begin
            if (status.out_free) begin
               cmd.load_delim = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: tb/sv/lexer_with_symbol_table_test.sv
// Self-checking testbench for lexer_with_symbol_table: directed bytes, then random
// token streams, checked against an in-bench token predictor. Depends on lxst_pkg.
module lexer_with_symbol_table_test import lxst_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEXEME  = 32;
   localparam int TABLE_DEPTH = 64;
   localparam int N_ITEMS     = 1450;
   localparam int IDLE_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 400;

   typedef logic [7:0] chars_type[$];

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] value;
      logic        full;
      logic        last;
   } token_type;

   typedef struct {
      logic [7:0]  ch;
      bit          typed;
      logic [2:0]  kind;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_char_code = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_token_kind;
   logic [15:0] rsp_token_value;
   logic        rsp_table_full;
   logic        rsp_last;

   lexer_with_symbol_table #(.MAX_LEXEME(MAX_LEXEME), .TABLE_DEPTH(TABLE_DEPTH)) DUT (.*);

   always #2 clock = ~clock;

   // Predictor state
   chars_type lexeme;
   chars_type symbols[$];
   chars_type keywords[NUM_KEYWORDS];
   logic [15:0] num_count;
   token_type  token_q[$];
   chars_type  ident_pool[$];
   int errors = 0;
   int idle_cycles = 0;
   int sent = 0;
   int tokens_seen = 0;
   bit burst_mode = 0;

   function automatic bit delim(input logic [7:0] c);
      return c inside {" ", "\t", "\n", "(", ")", "{", "}", ";", "=", "<", ">", "*"};
   endfunction

   function automatic chars_type to_chars(input string s);
      chars_type q;
      foreach (s[i]) q.push_back(s[i]);
      return q;
   endfunction

   function automatic void push_token(input logic [2:0] k, input logic [15:0] v,
                                      input logic f, input logic l);
      token_type t;
      t.kind = k; t.value = v; t.full = f; t.last = l;
      token_q.push_back(t);
   endfunction

   // Expected tokens for one accepted byte
   function automatic void predict_tokens(input logic [7:0] c);
      int kw, hit;
      kw = -1; hit = -1;
      if (!delim(c)) begin
         if (lexeme.size() < MAX_LEXEME) lexeme.push_back(c);
         return;
      end
      if (lexeme.size() > 0) begin
         foreach (keywords[i]) if (kw < 0 && keywords[i] == lexeme) kw = i;
         if (kw >= 0) begin
            push_token(KIND_KEYWORD, 16'(kw), 1'b0, 1'b0);
         end else if (lexeme[0] >= "0" && lexeme[0] <= "9") begin
            num_count++;
            push_token(KIND_NUMBER, num_count, 1'b0, 1'b0);
         end else begin
            foreach (symbols[e]) if (hit < 0 && symbols[e] == lexeme) hit = e;
            if (hit >= 0) begin
               push_token(KIND_IDENT, 16'(hit + 1), 1'b0, 1'b0);
            end else if (symbols.size() < TABLE_DEPTH) begin
               symbols.push_back(lexeme);
               push_token(KIND_IDENT, 16'(symbols.size()), 1'b0, 1'b0);
            end else begin
               push_token(KIND_IDENT, 16'd0, 1'b1, 1'b0);
            end
         end
      end
      push_token((c == " " || c == "\t" || c == "\n") ? KIND_SPACE : KIND_DELIM,
                 16'(c), 1'b0, 1'b1);
      lexeme.delete();
   endfunction

   // Send one byte; typed rows replace the predicted delimiter token
   task automatic send_byte(input logic [7:0] c, input bit typed = 0,
                            input logic [2:0] kind = 0);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 19);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_char_code <= c;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_tokens(c);
      if (typed) begin
         token_q[$].kind  = kind;
         token_q[$].value = 16'(c);
      end
      sent++;
   endtask

   task automatic send_chars(input chars_type q);
      foreach (q[i]) send_byte(q[i]);
   endtask

   // Compare each accepted transaction with the oldest expected token
   always @(posedge clock) begin
      token_type t;
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_cycles = 0;
      else if (!reset)
         idle_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_seen++;
         if (token_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected token kind %0d value %0d",
                                       rsp_token_kind, rsp_token_value);
         end else begin
            t = token_q.pop_front();
            if (t.kind !== rsp_token_kind || t.value !== rsp_token_value ||
                t.full !== rsp_table_full || t.last !== rsp_last) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp k%0d v%0d f%0d l%0d, got k%0d v%0d f%0d l%0d",
                           t.kind, t.value, t.full, t.last, rsp_token_kind,
                           rsp_token_value, rsp_table_full, rsp_last);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold to back the block up
   initial begin
      int gap;
      bit held;
      held = 0;
      wait (!reset);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 19);
         if (!held && tokens_seen > 200) begin
            gap = HOLD_CYCLES;
            held = 1;
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_stall <= 1;
         end
         @(negedge clock);
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Stimulus
   initial begin
      row_type rows[$];
      chars_type w;
      int r, len, d;
      logic [7:0] b;
      logic [7:0] delims[12] = '{" ", "\t", "\n", "(", ")", "{", "}", ";", "=", "<",
                                 ">", "*"};
      keywords[0] = to_chars("int");  keywords[1] = to_chars("main");
      keywords[2] = to_chars("if");   keywords[3] = to_chars("else");
      keywords[4] = to_chars("char"); keywords[5] = to_chars("return");
      num_count = 0;

      // Identifier pool larger than the table so it overflows
      for (int i = 0; i < 90; i++) begin
         w.delete();
         len = $urandom_range(1, 5);
         w.push_back(8'("a" + $urandom_range(0, 25)));
         for (int j = 1; j < len; j++) w.push_back(8'("_" + $urandom_range(0, 28)));
         ident_pool.push_back(w);
      end

      // Directed rows: empty lexeme, keyword, 0x00/0xFF bytes, number, known ident
      rows = '{'{";", 1, KIND_DELIM}, '{"i", 0, 0}, '{"n", 0, 0}, '{"t", 0, 0},
               '{"(", 1, KIND_DELIM}, '{8'h00, 0, 0}, '{8'hFF, 0, 0},
               '{"{", 1, KIND_DELIM}, '{"9", 0, 0}, '{"*", 1, KIND_DELIM},
               '{"x", 0, 0}, '{"\t", 1, KIND_SPACE}, '{"x", 0, 0},
               '{"\n", 1, KIND_SPACE}, '{"}", 1, KIND_DELIM}, '{" ", 1, KIND_SPACE},
               '{"<", 1, KIND_DELIM}, '{">", 1, KIND_DELIM}, '{"=", 1, KIND_DELIM},
               '{")", 1, KIND_DELIM}};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (rows[i]) send_byte(rows[i].ch, rows[i].typed, rows[i].kind);

      // Random token streams with some noise and over-long lexemes
      while (sent < N_ITEMS) begin
         if ($urandom_range(0, 9) == 0) burst_mode = !burst_mode;
         r = $urandom_range(0, 99);
         w.delete();
         if (r < 15) begin
            w = keywords[$urandom_range(0, NUM_KEYWORDS - 1)];
         end else if (r < 30) begin
            w.push_back(8'("0" + $urandom_range(0, 9)));
            len = $urandom_range(0, 4);
            repeat (len) w.push_back(8'("0" + $urandom_range(0, 9)));
         end else if (r < 85) begin
            w = ident_pool[$urandom_range(0, ident_pool.size() - 1)];
         end else if (r < 90) begin
            len = $urandom_range(MAX_LEXEME - 2, MAX_LEXEME + 8);
            repeat (len) begin
               do b = 8'($urandom_range(0, 255)); while (delim(b));
               w.push_back(b);
            end
         end else begin
            w.push_back(8'($urandom_range(0, 255)));
         end
         send_chars(w);
         d = $urandom_range(0, 11);
         send_byte(delims[d]);
      end
      burst_mode = 0;
      @(negedge clock);
      req_valid <= 0;

      // Drain, then allow the block to settle
      wait (token_q.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && token_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
